// File: src/terminal_line_editor_top_defines.svh
// Assertion macros shared by the line editor RTL.
`ifndef TERMINAL_LINE_EDITOR_TOP_DEFINES_SVH
`define TERMINAL_LINE_EDITOR_TOP_DEFINES_SVH

// Same-cycle implication checked at every rising clock edge outside reset.
`define TLE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("line editor assertion failed");

// Next-cycle implication checked at every rising clock edge outside reset.
`define TLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("line editor assertion failed");

`endif

// File: src/tle_pkg.sv
// Shared constants, codes and types of the terminal line editor.
`timescale 1ns / 1ps
package tle_pkg;

   // Line store geometry.
   localparam int CAP    = 64;
   localparam int ADDR_W = (CAP > 1) ? $clog2(CAP) : 1;
   localparam int CNT_W  = $clog2(CAP + 1);

   // Fixed field widths of the channels.
   localparam int BYTE_W  = 8;
   localparam int POS_W   = 7;
   localparam int LIMIT_W = 7;
   localparam int KIND_W  = 2;

   localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;
   localparam logic [LIMIT_W-1:0] LIMIT_MAX   = LIMIT_W'(CAP);
   localparam logic [LIMIT_W-1:0] LIMIT_MIN   = 7'd1;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_STATUS = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CHAR   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_EMPTY  = 2'd2;

   // Escape sequence progress.
   localparam logic [1:0] ESC_NONE    = 2'd0;
   localparam logic [1:0] ESC_SEEN    = 2'd1;
   localparam logic [1:0] ESC_BRACKET = 2'd2;
   localparam logic [1:0] ESC_THREE   = 2'd3;

   // Byte codes.
   localparam logic [BYTE_W-1:0] KEY_ESC       = 8'd27;
   localparam logic [BYTE_W-1:0] KEY_ENTER     = 8'd13;
   localparam logic [BYTE_W-1:0] KEY_BACKSPACE = 8'd127;
   localparam logic [BYTE_W-1:0] CHR_LBRACKET  = 8'h5B;
   localparam logic [BYTE_W-1:0] CHR_TILDE     = 8'h7E;
   localparam logic [BYTE_W-1:0] CHR_RIGHT     = 8'h43;
   localparam logic [BYTE_W-1:0] CHR_LEFT      = 8'h44;
   localparam logic [BYTE_W-1:0] CHR_THREE     = 8'h33;

   typedef enum logic [8:0] {
      ST_IDLE       = 9'b000000001,
      ST_SHIFT_UP   = 9'b000000010,
      ST_PUT        = 9'b000000100,
      ST_SHIFT_DOWN = 9'b000001000,
      ST_DRAIN      = 9'b000010000,
      ST_STATUS     = 9'b000100000,
      ST_EMIT_RD    = 9'b001000000,
      ST_EMIT_WR    = 9'b010000000,
      ST_EMPTY      = 9'b100000000
   } state_type;

   function automatic logic is_insertable(input logic [BYTE_W-1:0] b);
      return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A) ||
             (b >= 8'h30 && b <= 8'h39) || b == 8'h20 || b == 8'h2F ||
             b == 8'h3D || b == 8'h3B;
   endfunction

endpackage

// File: src/tle_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps
module tle_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/terminal_line_editor_top.sv
// Terminal line editor: edits one line in a RAM and emits it on Enter or when full.
//
// Usage:
//   req_* carries received serial bytes, one byte per beat in req_tdata[7:0].
//   rsp_* carries results. Every byte gives one status beat (tuser kind 0),
//   except Enter or a filling insert, which give one beat per line character
//   (kind 1) or a single empty-line beat (kind 2). tlast marks the final beat
//   of a byte. csr_* writes the line limit; csr_ready is always high.
// Sequencing:
//   A byte is taken only while the sequencer is idle, so the next byte waits
//   until the sequencer is through with the last one. The single RAM read port
//   shifts the line one entry per cycle during an insert or a delete. Emitting
//   alternates a read state and an output state for each character and waits
//   while the output register is held. Each beat shows on rsp_* the cycle after
//   it is loaded.
// Reset: cursor, length and escape state clear, the limit returns to 64 and
//   the output register empties. The store itself is not cleared.
// Stall: while rsp_tready is low the output beat holds and the sequencer
//   waits; a new byte may be taken while the last status beat still waits.
`timescale 1ns / 1ps
`include "terminal_line_editor_top_defines.svh"
module terminal_line_editor_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] received_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,   // [7:0] character, [14:8] cursor_position,
                                    // [21:15] line_length, [23:22] zero
   output logic [2:0]  rsp_tuser,   // [1:0] result_kind, [2] ended_full
   output logic        rsp_tlast,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [6:0]  csr_data     // [6:0] line_limit
);

   localparam int AW = tle_pkg::ADDR_W;
   localparam int CW = tle_pkg::CNT_W;

   tle_pkg::state_type state_ff, state_in;

   logic [CW-1:0]                 cursor_ff, cursor_in;
   logic [CW-1:0]                 length_ff, length_in;
   logic [1:0]                    phase_ff, phase_in;
   logic [tle_pkg::LIMIT_W-1:0]   limit_ff, limit_in;
   logic [CW-1:0]                 src_ff, src_in;
   logic [CW-1:0]                 emit_len_ff, emit_len_in;
   logic                          emit_full_ff, emit_full_in;
   logic [tle_pkg::BYTE_W-1:0]    byte_ff, byte_in;
   logic                          pend_ff, pend_in;
   logic [AW-1:0]                 pend_addr_ff, pend_addr_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [tle_pkg::KIND_W-1:0]    rsp_kind_ff;
   logic [tle_pkg::BYTE_W-1:0]    rsp_char_ff;
   logic [tle_pkg::POS_W-1:0]     rsp_cur_ff;
   logic [tle_pkg::POS_W-1:0]     rsp_len_ff;
   logic                          rsp_last_ff;
   logic                          rsp_full_ff;

   logic                          out_load;
   logic [tle_pkg::KIND_W-1:0]    out_kind;
   logic [tle_pkg::BYTE_W-1:0]    out_char;
   logic [tle_pkg::POS_W-1:0]     out_cur;
   logic [tle_pkg::POS_W-1:0]     out_len;
   logic                          out_last;
   logic                          out_full;

   logic                          req_accept;
   logic                          slot_free;
   logic [tle_pkg::BYTE_W-1:0]    b;
   logic [tle_pkg::LIMIT_W-1:0]   limit_eff;
   logic [CW-1:0]                 new_len;
   logic [CW-1:0]                 rm_pos;
   logic                          do_remove, do_insert, emit_start;
   logic [CW-1:0]                 emit_len_sel;
   logic                          emit_full_sel;

   logic                          ram_wr_en;
   logic [AW-1:0]                 ram_wr_addr;
   logic [tle_pkg::BYTE_W-1:0]    ram_wr_data;
   logic [AW-1:0]                 ram_rd_addr;
   logic [tle_pkg::BYTE_W-1:0]    ram_rd_data;
   logic                          put_wr;

   assign b          = req_tdata;
   assign req_tready = (state_ff == tle_pkg::ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign slot_free  = !rsp_valid_ff || rsp_tready;
   assign csr_ready  = 1'b1;
   assign new_len    = length_ff + 1'b1;

   always_comb begin
      if (limit_ff == '0) begin
         limit_eff = tle_pkg::LIMIT_MIN;
      end else if (limit_ff > tle_pkg::LIMIT_MAX) begin
         limit_eff = tle_pkg::LIMIT_MAX;
      end else begin
         limit_eff = limit_ff;
      end
   end

   always_comb begin
      state_in      = state_ff;
      cursor_in     = cursor_ff;
      length_in     = length_ff;
      phase_in      = phase_ff;
      limit_in      = limit_ff;
      src_in        = src_ff;
      emit_len_in   = emit_len_ff;
      emit_full_in  = emit_full_ff;
      byte_in       = byte_ff;
      pend_in       = 1'b0;
      pend_addr_in  = pend_addr_ff;
      out_load      = 1'b0;
      out_kind      = tle_pkg::KIND_STATUS;
      out_char      = '0;
      out_cur       = tle_pkg::POS_W'(cursor_ff);
      out_len       = tle_pkg::POS_W'(length_ff);
      out_last      = 1'b1;
      out_full      = 1'b0;
      do_remove     = 1'b0;
      do_insert     = 1'b0;
      emit_start    = 1'b0;
      emit_len_sel  = length_ff;
      emit_full_sel = 1'b0;
      rm_pos        = cursor_ff;
      ram_rd_addr   = '0;
      put_wr        = 1'b0;

      if (csr_valid) begin
         limit_in = csr_data;
      end

      unique case (state_ff)
         tle_pkg::ST_IDLE: begin
            if (req_accept) begin
               state_in = tle_pkg::ST_STATUS;
               case (phase_ff)
                  tle_pkg::ESC_SEEN: begin
                     phase_in = (b == tle_pkg::CHR_LBRACKET) ? tle_pkg::ESC_BRACKET
                                                             : tle_pkg::ESC_NONE;
                  end
                  tle_pkg::ESC_BRACKET: begin
                     phase_in = tle_pkg::ESC_NONE;
                     if (b == tle_pkg::CHR_RIGHT) begin
                        if (cursor_ff < length_ff) cursor_in = cursor_ff + 1'b1;
                     end else if (b == tle_pkg::CHR_LEFT) begin
                        if (cursor_ff != '0) cursor_in = cursor_ff - 1'b1;
                     end else if (b == tle_pkg::CHR_THREE) begin
                        phase_in = tle_pkg::ESC_THREE;
                     end
                  end
                  tle_pkg::ESC_THREE: begin
                     phase_in = tle_pkg::ESC_NONE;
                     if (b == tle_pkg::CHR_TILDE && cursor_ff < length_ff) begin
                        do_remove = 1'b1;
                     end
                  end
                  default: begin
                     if (b == tle_pkg::KEY_ESC) begin
                        phase_in = tle_pkg::ESC_SEEN;
                     end else if (b == tle_pkg::KEY_ENTER) begin
                        emit_start = 1'b1;
                     end else if (b == tle_pkg::KEY_BACKSPACE) begin
                        if (cursor_ff != '0) begin
                           cursor_in = cursor_ff - 1'b1;
                           rm_pos    = cursor_ff - 1'b1;
                           do_remove = 1'b1;
                        end
                     end else if (tle_pkg::is_insertable(b) &&
                                  length_ff < CW'(tle_pkg::CAP)) begin
                        do_insert = 1'b1;
                     end
                  end
               endcase

               // Removal moves the tail down one place, starting just above it.
               if (do_remove) begin
                  if (rm_pos + 1'b1 < length_ff) begin
                     src_in   = rm_pos + 1'b1;
                     state_in = tle_pkg::ST_SHIFT_DOWN;
                  end else begin
                     length_in = length_ff - 1'b1;
                  end
               end
               if (do_insert) begin
                  byte_in = b;
                  if (length_ff > cursor_ff) begin
                     src_in   = length_ff - 1'b1;
                     state_in = tle_pkg::ST_SHIFT_UP;
                  end else begin
                     state_in = tle_pkg::ST_PUT;
                  end
               end
            end
         end

         tle_pkg::ST_SHIFT_UP: begin
            ram_rd_addr  = src_ff[AW-1:0];
            pend_in      = 1'b1;
            pend_addr_in = AW'(src_ff + 1'b1);
            if (src_ff == cursor_ff) begin
               state_in = tle_pkg::ST_PUT;
            end else begin
               src_in = src_ff - 1'b1;
            end
         end

         tle_pkg::ST_PUT: begin
            // The last shifted entry is written first; the new byte follows.
            if (!pend_ff) begin
               put_wr    = 1'b1;
               length_in = new_len;
               cursor_in = cursor_ff + 1'b1;
               if (tle_pkg::LIMIT_W'(new_len) >= limit_eff) begin
                  emit_start    = 1'b1;
                  emit_len_sel  = new_len;
                  emit_full_sel = 1'b1;
               end else begin
                  state_in = tle_pkg::ST_STATUS;
               end
            end
         end

         tle_pkg::ST_SHIFT_DOWN: begin
            ram_rd_addr  = src_ff[AW-1:0];
            pend_in      = 1'b1;
            pend_addr_in = AW'(src_ff - 1'b1);
            if (src_ff + 1'b1 == length_ff) begin
               state_in = tle_pkg::ST_DRAIN;
            end else begin
               src_in = src_ff + 1'b1;
            end
         end

         tle_pkg::ST_DRAIN: begin
            length_in = length_ff - 1'b1;
            state_in  = tle_pkg::ST_STATUS;
         end

         tle_pkg::ST_STATUS: begin
            if (slot_free) begin
               out_load = 1'b1;
               state_in = tle_pkg::ST_IDLE;
            end
         end

         tle_pkg::ST_EMIT_RD: begin
            ram_rd_addr = src_ff[AW-1:0];
            if (slot_free) begin
               state_in = tle_pkg::ST_EMIT_WR;
            end
         end

         tle_pkg::ST_EMIT_WR: begin
            out_load = 1'b1;
            out_kind = tle_pkg::KIND_CHAR;
            out_char = ram_rd_data;
            out_cur  = '0;
            out_len  = '0;
            out_last = (src_ff + 1'b1 == emit_len_ff);
            out_full = emit_full_ff;
            src_in   = src_ff + 1'b1;
            state_in = out_last ? tle_pkg::ST_IDLE : tle_pkg::ST_EMIT_RD;
         end

         tle_pkg::ST_EMPTY: begin
            if (slot_free) begin
               out_load = 1'b1;
               out_kind = tle_pkg::KIND_EMPTY;
               out_cur  = '0;
               out_len  = '0;
               state_in = tle_pkg::ST_IDLE;
            end
         end

         default: begin
            state_in = tle_pkg::ST_IDLE;
         end
      endcase

      if (emit_start) begin
         cursor_in    = '0;
         length_in    = '0;
         src_in       = '0;
         emit_len_in  = emit_len_sel;
         emit_full_in = emit_full_sel;
         state_in     = (emit_len_sel == '0) ? tle_pkg::ST_EMPTY : tle_pkg::ST_EMIT_RD;
      end
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   assign ram_wr_en   = pend_ff || put_wr;
   assign ram_wr_addr = pend_ff ? pend_addr_ff : cursor_ff[AW-1:0];
   assign ram_wr_data = pend_ff ? ram_rd_data : byte_ff;

   tle_ram #(
      .WIDTH (tle_pkg::BYTE_W),
      .DEPTH (tle_pkg::CAP)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= tle_pkg::ST_IDLE;
         cursor_ff    <= '0;
         length_ff    <= '0;
         phase_ff     <= tle_pkg::ESC_NONE;
         limit_ff     <= tle_pkg::LIMIT_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cursor_ff    <= cursor_in;
         length_ff    <= length_in;
         phase_ff     <= phase_in;
         limit_ff     <= limit_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      src_ff       <= src_in;
      emit_len_ff  <= emit_len_in;
      emit_full_ff <= emit_full_in;
      byte_ff      <= byte_in;
      pend_addr_ff <= pend_addr_in;
      if (out_load) begin
         rsp_kind_ff <= out_kind;
         rsp_char_ff <= out_char;
         rsp_cur_ff  <= out_cur;
         rsp_len_ff  <= out_len;
         rsp_last_ff <= out_last;
         rsp_full_ff <= out_full;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_len_ff, rsp_cur_ff, rsp_char_ff};
   assign rsp_tuser  = {rsp_full_ff, rsp_kind_ff};
   assign rsp_tlast  = rsp_last_ff;

   `TLE_ASSERT_NOW(a_cursor_in_line, clock, reset, 1'b1, cursor_ff <= length_ff)
   `TLE_ASSERT_NOW(a_length_in_store, clock, reset, 1'b1, length_ff <= CW'(tle_pkg::CAP))
   `TLE_ASSERT_NOW(a_pend_only_in_shift, clock, reset, pend_ff,
      state_ff == tle_pkg::ST_SHIFT_UP || state_ff == tle_pkg::ST_SHIFT_DOWN ||
      state_ff == tle_pkg::ST_DRAIN || state_ff == tle_pkg::ST_PUT)
   `TLE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_accept,
      state_ff != tle_pkg::ST_IDLE)

endmodule

// File: tb/tb_terminal_line_editor_top.sv
// Self-checking testbench for the terminal line editor: scripted and random keys, checked beats.
`timescale 1ns / 1ps
module tb_terminal_line_editor_top;

   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_Z = 8'h7A;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CH_DIGIT_0 = 8'h30;
   localparam logic [7:0] CH_DIGIT_9 = 8'h39;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_SLASH   = 8'h2F;
   localparam logic [7:0] CH_EQUALS  = 8'h3D;
   localparam logic [7:0] CH_SEMI    = 8'h3B;

   typedef enum logic [1:0] {OP_KEY, OP_LIMIT, OP_HOLD} script_op_type;

   typedef struct packed {
      script_op_type op;
      logic [7:0]    value;
   } script_entry_type;

   typedef struct packed {
      logic [tle_pkg::KIND_W-1:0] kind;
      logic [7:0]                 ch;
      logic [tle_pkg::POS_W-1:0]  cur;
      logic [tle_pkg::POS_W-1:0]  len;
      logic                       last;
      logic                       full;
   } editor_beat_type;

   logic                        clock      = 1'b0;
   logic                        reset      = 1'b1;
   logic                        req_tvalid = 1'b0;
   logic [7:0]                  req_tdata  = '0;
   logic                        rsp_tready = 1'b0;
   logic                        csr_valid  = 1'b0;
   logic [tle_pkg::LIMIT_W-1:0] csr_data   = '0;
   logic                        req_tready;
   logic                        rsp_tvalid;
   logic [23:0]                 rsp_tdata;
   logic [2:0]                  rsp_tuser;
   logic                        rsp_tlast;
   logic                        csr_ready;

   script_entry_type   input_script[$];
   editor_beat_type    expected_beats[$];
   int                 beats_predicted = 0;
   int                 beats_checked   = 0;
   int                 mismatch_count  = 0;
   int                 send_wait  = 0;
   int                 send_calm  = 0;
   int                 recv_wait  = 0;
   int                 recv_calm  = 0;

   // Shadow copy of the editor state.
   logic [7:0]                  shadow_line[tle_pkg::CAP];
   int                          shadow_cursor = 0;
   int                          shadow_len    = 0;
   logic [1:0]                  shadow_esc    = tle_pkg::ESC_NONE;
   logic [tle_pkg::LIMIT_W-1:0] shadow_limit  = tle_pkg::LIMIT_RESET;

   terminal_line_editor_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   initial begin
      #25_000_000;
      $display("terminal_line_editor_top: mismatch");
      $finish;
   end

   // Mostly random waits, with occasional stretches of back-to-back beats.
   function automatic int draw_wait(inout int calm);
      if (calm > 0) begin
         calm--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0) begin
         calm = $urandom_range(8, 30);
         return 0;
      end
      return $urandom_range(0, 18);
   endfunction

   function automatic bit can_insert(input logic [7:0] b);
      return (b >= CH_LOWER_A && b <= CH_LOWER_Z) || (b >= CH_UPPER_A && b <= CH_UPPER_Z) ||
             (b >= CH_DIGIT_0 && b <= CH_DIGIT_9) || b == CH_SPACE || b == CH_SLASH ||
             b == CH_EQUALS || b == CH_SEMI;
   endfunction

   function automatic logic [7:0] random_printable();
      case ($urandom_range(0, 6))
         0: return CH_LOWER_A + 8'($urandom_range(0, 25));
         1: return CH_UPPER_A + 8'($urandom_range(0, 25));
         2: return CH_DIGIT_0 + 8'($urandom_range(0, 9));
         3: return CH_SPACE;
         4: return CH_SLASH;
         5: return CH_EQUALS;
         default: return CH_SEMI;
      endcase
   endfunction

   task automatic add_key(input logic [7:0] b);
      input_script.push_back('{op: OP_KEY, value: b});
   endtask

   task automatic add_limit(input logic [7:0] v);
      input_script.push_back('{op: OP_LIMIT, value: v});
   endtask

   task automatic add_escape(input logic [7:0] final_byte);
      add_key(tle_pkg::KEY_ESC);
      add_key(tle_pkg::CHR_LBRACKET);
      add_key(final_byte);
   endtask

   task automatic add_delete();
      add_escape(tle_pkg::CHR_THREE);
      add_key(tle_pkg::CHR_TILDE);
   endtask

   task automatic push_beat(input logic [tle_pkg::KIND_W-1:0] kind, input logic [7:0] ch,
                            input int cur, input int len, input logic last,
                            input logic full);
      expected_beats.push_back('{kind: kind, ch: ch, cur: cur[tle_pkg::POS_W-1:0],
                                 len: len[tle_pkg::POS_W-1:0], last: last, full: full});
      beats_predicted++;
   endtask

   task automatic drop_char(input int pos);
      for (int i = pos; i + 1 < shadow_len; i++)
         shadow_line[i] = shadow_line[i + 1];
      shadow_len--;
   endtask

   // Applies one received byte to the shadow line and queues the beats it causes.
   task automatic predict_edit(input logic [7:0] b);
      int lim;
      bit ends_line;
      bit ends_full;
      int n;
      lim = shadow_limit;
      if (lim < 1) lim = 1;
      if (lim > tle_pkg::CAP) lim = tle_pkg::CAP;
      ends_line = 1'b0;
      ends_full = 1'b0;
      case (shadow_esc)
         tle_pkg::ESC_SEEN: begin
            shadow_esc = (b == tle_pkg::CHR_LBRACKET) ? tle_pkg::ESC_BRACKET
                                                      : tle_pkg::ESC_NONE;
         end
         tle_pkg::ESC_BRACKET: begin
            shadow_esc = tle_pkg::ESC_NONE;
            if (b == tle_pkg::CHR_RIGHT) begin
               if (shadow_cursor < shadow_len) shadow_cursor++;
            end else if (b == tle_pkg::CHR_LEFT) begin
               if (shadow_cursor > 0) shadow_cursor--;
            end else if (b == tle_pkg::CHR_THREE) begin
               shadow_esc = tle_pkg::ESC_THREE;
            end
         end
         tle_pkg::ESC_THREE: begin
            shadow_esc = tle_pkg::ESC_NONE;
            if (b == tle_pkg::CHR_TILDE && shadow_cursor < shadow_len)
               drop_char(shadow_cursor);
         end
         default: begin
            if (b == tle_pkg::KEY_ESC) begin
               shadow_esc = tle_pkg::ESC_SEEN;
            end else if (b == tle_pkg::KEY_ENTER) begin
               ends_line = 1'b1;
            end else if (b == tle_pkg::KEY_BACKSPACE) begin
               if (shadow_cursor > 0) begin
                  shadow_cursor--;
                  drop_char(shadow_cursor);
               end
            end else if (can_insert(b) && shadow_len < tle_pkg::CAP) begin
               for (int i = shadow_len; i > shadow_cursor; i--)
                  shadow_line[i] = shadow_line[i - 1];
               shadow_line[shadow_cursor] = b;
               shadow_len++;
               shadow_cursor++;
               if (shadow_len >= lim) begin
                  ends_line = 1'b1;
                  ends_full = 1'b1;
               end
            end
         end
      endcase
      if (ends_line) begin
         n = shadow_len;
         shadow_len = 0;
         shadow_cursor = 0;
         if (n == 0)
            push_beat(tle_pkg::KIND_EMPTY, 8'h00, 0, 0, 1'b1, 1'b0);
         for (int i = 0; i < n; i++)
            push_beat(tle_pkg::KIND_CHAR, shadow_line[i], 0, 0, i == n - 1, ends_full);
      end else begin
         push_beat(tle_pkg::KIND_STATUS, 8'h00, shadow_cursor, shadow_len, 1'b1, 1'b0);
      end
   endtask

   // Sender: keys and limit writes come from the script in order.
   always @(posedge clock) begin : drive
      logic next_req;
      logic next_csr;
      if (reset) begin
         req_tvalid <= 1'b0;
         csr_valid  <= 1'b0;
      end else begin
         next_req = req_tvalid;
         next_csr = csr_valid;
         if (req_tvalid && req_tready) begin
            predict_edit(req_tdata);
            next_req  = 1'b0;
            send_wait = draw_wait(send_calm);
         end
         if (csr_valid && csr_ready) begin
            shadow_limit = csr_data;
            next_csr  = 1'b0;
            send_wait = draw_wait(send_calm);
         end
         if (!next_req && !next_csr) begin
            if (send_wait > 0) begin
               send_wait--;
            end else if (input_script.size() > 0) begin
               case (input_script[0].op)
                  OP_KEY: begin
                     next_req = 1'b1;
                     req_tdata <= input_script[0].value;
                     void'(input_script.pop_front());
                  end
                  OP_LIMIT: begin
                     // The limit only changes once the editor has drained.
                     if (beats_predicted == beats_checked) begin
                        next_csr = 1'b1;
                        csr_data <= input_script[0].value[tle_pkg::LIMIT_W-1:0];
                        void'(input_script.pop_front());
                     end
                  end
                  default: begin
                     if (beats_predicted == beats_checked) void'(input_script.pop_front());
                  end
               endcase
            end
         end
         req_tvalid <= next_req;
         csr_valid  <= next_csr;
      end
   end

   // Receiver: checks every result beat against the oldest expectation.
   always @(posedge clock) begin : watch
      editor_beat_type want;
      logic [23:0]     want_data;
      logic [2:0]      want_user;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_beats.size() == 0) begin
               if (mismatch_count < 10)
                  $display("unexpected result beat: data %h user %h last %b",
                           rsp_tdata, rsp_tuser, rsp_tlast);
               mismatch_count++;
            end else begin
               want = expected_beats.pop_front();
               beats_checked <= beats_checked + 1;
               want_data = {2'b00, want.len, want.cur, want.ch};
               want_user = {want.full, want.kind};
               if (rsp_tdata !== want_data || rsp_tuser !== want_user ||
                   rsp_tlast !== want.last) begin
                  if (mismatch_count < 10)
                     $display("beat %0d: want data %h user %h last %b, got data %h user %h last %b",
                              beats_checked, want_data, want_user, want.last,
                              rsp_tdata, rsp_tuser, rsp_tlast);
                  mismatch_count++;
               end
            end
            recv_wait = draw_wait(recv_calm);
         end
         if (recv_wait > 0) begin
            recv_wait--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   initial begin : stimulus
      string first_line;
      string second_line;
      int    added;
      int    hold_at;
      int    r;
      logic [7:0] phase_limit[6];
      first_line = "aZ09 /=;";
      second_line = "abcde";
      foreach (shadow_line[i]) shadow_line[i] = 8'h00;

      // Directed edits at the reset limit.
      add_key(tle_pkg::KEY_ENTER);
      add_key(8'h00);
      add_key(8'hFF);
      add_key(tle_pkg::KEY_BACKSPACE);
      foreach (first_line[i]) add_key(first_line[i]);
      add_escape(tle_pkg::CHR_LEFT);
      add_key(tle_pkg::KEY_BACKSPACE);
      add_delete();
      add_escape(tle_pkg::CHR_RIGHT);
      add_key(tle_pkg::KEY_ENTER);

      // Smallest limits, including a value that clamps up to one.
      add_limit(8'd1);
      add_key("q");
      add_key("7");
      add_limit(8'd0);
      add_key("x");

      // Lowering the limit below a partial line ends it on the next insert.
      add_limit(8'd64);
      foreach (second_line[i]) add_key(second_line[i]);
      add_limit(8'd3);
      add_key("f");
      add_key("g");
      add_key("h");
      add_key("i");

      // A value that clamps to the capacity, then one full-size line.
      add_limit(8'd127);
      for (int i = 0; i < tle_pkg::CAP; i++) add_key(random_printable());

      phase_limit[0] = 8'd64;
      phase_limit[1] = 8'd6;
      phase_limit[2] = 8'd2;
      phase_limit[3] = 8'd20;
      phase_limit[4] = 8'($urandom_range(0, 127));
      phase_limit[5] = 8'd9;
      for (int p = 0; p < 6; p++) begin
         add_limit(phase_limit[p]);
         added = 0;
         hold_at = $urandom_range(1, 5);
         while (added < 9) begin
            if (added >= hold_at && hold_at >= 0) begin
               input_script.push_back('{op: OP_HOLD, value: 8'h00});
               hold_at = -1;
            end
            r = $urandom_range(0, 99);
            if (r < 45) begin
               add_key(random_printable());
               added += 1;
            end else if (r < 53) begin
               add_key(tle_pkg::KEY_BACKSPACE);
               added += 1;
            end else if (r < 61) begin
               add_escape(tle_pkg::CHR_LEFT);
               added += 3;
            end else if (r < 67) begin
               add_escape(tle_pkg::CHR_RIGHT);
               added += 3;
            end else if (r < 73) begin
               add_delete();
               added += 4;
            end else if (r < 80) begin
               add_key(tle_pkg::KEY_ENTER);
               added += 1;
            end else if (r < 88) begin
               add_key(8'($urandom_range(0, 255)));
               added += 1;
            end else begin
               // A sequence cut short at a random point by a random byte.
               add_key(tle_pkg::KEY_ESC);
               case ($urandom_range(0, 2))
                  0: ;
                  1: add_key(tle_pkg::CHR_LBRACKET);
                  default: begin
                     add_key(tle_pkg::CHR_LBRACKET);
                     add_key(tle_pkg::CHR_THREE);
                  end
               endcase
               add_key(8'($urandom_range(0, 255)));
               added += 3;
            end
         end
      end
      add_key(tle_pkg::KEY_ENTER);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      @(negedge clock);
      while (input_script.size() > 0 || req_tvalid || csr_valid ||
             beats_predicted != beats_checked)
         @(negedge clock);
      repeat (300) @(posedge clock);
      if (mismatch_count == 0 && expected_beats.size() == 0) begin
         $display("terminal_line_editor_top: match");
      end else begin
         $display("terminal_line_editor_top: mismatch");
      end
      $finish;
   end

endmodule

// File: sim.f
+incdir+src
src/tle_pkg.sv
src/tle_ram.sv
src/terminal_line_editor_top.sv
tb/tb_terminal_line_editor_top.sv
